// ===== design/rcgq_pkg.sv =====
// Shared constants, stage types and arithmetic helpers for the RGB palette quantizer.
package rcgq_pkg;

  localparam int unsigned CUBE_LEVELS  = 6;
  localparam int unsigned CUBE_ENTRIES = 216;
  localparam int unsigned GRAY_STEPS   = 40;
  localparam int unsigned GRAY_SPAN    = GRAY_STEPS - 1;
  localparam int unsigned HALF_ROUND   = 127;
  localparam int unsigned FULL_SCALE   = 255;
  localparam int unsigned LEVEL_STEP   = FULL_SCALE / (CUBE_LEVELS - 1);
  localparam int unsigned AVG_RECIP    = 683;
  localparam int unsigned AVG_SHIFT    = 11;

  typedef logic [7:0] gray_lut_t [GRAY_STEPS];

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic [5:0] step;
    logic [7:0] cube_red;
    logic [7:0] cube_green;
    logic [7:0] cube_blue;
    logic [7:0] cube_index;
  } level_word_t;

  function automatic gray_lut_t gray_lut_init();
    gray_lut_t lut;
    for (int i = 0; i < int'(GRAY_STEPS); i++) begin
      lut[i] = 8'((i * FULL_SCALE) / GRAY_SPAN);
    end
    return lut;
  endfunction

  localparam gray_lut_t GRAY_LUT = gray_lut_init();

  // Exact floor(x / 255) for any x below 255 * 256.
  function automatic logic [7:0] div_full_scale(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

endpackage

// ===== design/rcgq_level.sv =====
// Front pipeline stages: cube levels, channel average, gray step and cube color.
module rcgq_level
  import rcgq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        pixel_valid,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        last_pixel,
  output logic        word_valid,
  output level_word_t word
);

  logic       s1_valid;
  logic [7:0] s1_red, s1_green, s1_blue;
  logic       s1_last;
  logic [2:0] s1_lvl_r, s1_lvl_g, s1_lvl_b;
  logic [7:0] s1_avg;

  logic [9:0]  sum_next;
  logic [19:0] avg_prod;
  logic [13:0] step_arg;
  logic [7:0]  step_full;
  logic [7:0]  index_rg;

  assign sum_next = 10'(red_in) + 10'(green_in) + 10'(blue_in);
  assign avg_prod = 20'(sum_next) * 20'(AVG_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_red   <= red_in;
      s1_green <= green_in;
      s1_blue  <= blue_in;
      s1_last  <= last_pixel;
      s1_lvl_r <= 3'(div_full_scale(16'(red_in) * 16'd5 + 16'(HALF_ROUND)));
      s1_lvl_g <= 3'(div_full_scale(16'(green_in) * 16'd5 + 16'(HALF_ROUND)));
      s1_lvl_b <= 3'(div_full_scale(16'(blue_in) * 16'd5 + 16'(HALF_ROUND)));
      s1_avg   <= avg_prod[AVG_SHIFT +: 8];
    end
  end

  assign step_arg  = 14'(s1_avg) * 14'(GRAY_SPAN) + 14'(HALF_ROUND);
  assign step_full = div_full_scale(16'(step_arg));
  assign index_rg  = 8'(s1_lvl_r) * 8'(CUBE_LEVELS) + 8'(s1_lvl_g);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (en) begin
      word_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word.red        <= s1_red;
      word.green      <= s1_green;
      word.blue       <= s1_blue;
      word.last       <= s1_last;
      word.step       <= step_full[5:0];
      word.cube_red   <= 8'(s1_lvl_r) * 8'(LEVEL_STEP);
      word.cube_green <= 8'(s1_lvl_g) * 8'(LEVEL_STEP);
      word.cube_blue  <= 8'(s1_lvl_b) * 8'(LEVEL_STEP);
      word.cube_index <= index_rg * 8'(CUBE_LEVELS) + 8'(s1_lvl_b);
    end
  end

endmodule

// ===== design/rcgq_select.sv =====
// Back pipeline stages: squared errors to cube and gray colors and the final choice.
module rcgq_select
  import rcgq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        word_valid,
  input  level_word_t word,
  output logic        result_valid,
  output logic [7:0]  palette_index,
  output logic        is_gray,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        last_out
);

  logic        s3_valid, s4_valid;
  level_word_t s3_word, s4_word;
  logic [7:0]  s3_gray, s4_gray;
  logic [15:0] s3_sq_r, s3_sq_g, s3_sq_b;
  logic [17:0] s4_cube_dist;
  logic [15:0] s4_gq_r, s4_gq_g, s4_gq_b;
  logic [17:0] gray_dist;
  logic        pick_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s3_valid     <= word_valid;
      s4_valid     <= s3_valid;
      result_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_word <= word;
      s3_gray <= GRAY_LUT[word.step];
      s3_sq_r <= sq_diff(word.red, word.cube_red);
      s3_sq_g <= sq_diff(word.green, word.cube_green);
      s3_sq_b <= sq_diff(word.blue, word.cube_blue);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_word      <= s3_word;
      s4_gray      <= s3_gray;
      s4_cube_dist <= 18'(s3_sq_r) + 18'(s3_sq_g) + 18'(s3_sq_b);
      s4_gq_r      <= sq_diff(s3_word.red, s3_gray);
      s4_gq_g      <= sq_diff(s3_word.green, s3_gray);
      s4_gq_b      <= sq_diff(s3_word.blue, s3_gray);
    end
  end

  assign gray_dist = 18'(s4_gq_r) + 18'(s4_gq_g) + 18'(s4_gq_b);
  assign pick_gray = gray_dist < s4_cube_dist;

  always_ff @(posedge clk) begin
    if (en) begin
      last_out <= s4_word.last;
      is_gray  <= pick_gray;
      if (pick_gray) begin
        palette_index <= 8'(CUBE_ENTRIES) + 8'(s4_word.step);
        out_red       <= s4_gray;
        out_green     <= s4_gray;
        out_blue      <= s4_gray;
      end else begin
        palette_index <= s4_word.cube_index;
        out_red       <= s4_word.cube_red;
        out_green     <= s4_word.cube_green;
        out_blue      <= s4_word.cube_blue;
      end
    end
  end

endmodule

// ===== design/rgb_cube_gray_quantizer.sv =====
// Top level of the RGB to 256-entry cube and gray ramp palette quantizer.
//
//   channel  direction  handshake                  payload
//   pixel    in         pixel_valid, pixel_stall   red_in, green_in, blue_in, last_pixel
//   result   out        result_valid, result_stall palette_index, is_gray, out_red,
//                                                  out_green, out_blue, last_out
//
// One word is accepted per cycle while the pipeline is not stalled, and each gives
// its result after the five register stages: levels and average, gray step and
// cube color, cube error squares, gray error squares, and the final choice.
// Reset clears only the stage valid bits. While a result waits under stall the
// whole pipeline holds and pixel_stall is raised.
module rgb_cube_gray_quantizer
  import rcgq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic       last_pixel,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] palette_index,
  output logic       is_gray,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       last_out
);

  logic        en;
  logic        word_valid;
  level_word_t word;

  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;

  rcgq_level u_level (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .pixel_valid (pixel_valid),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .last_pixel  (last_pixel),
    .word_valid  (word_valid),
    .word        (word)
  );

  rcgq_select u_select (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .word_valid    (word_valid),
    .word          (word),
    .result_valid  (result_valid),
    .palette_index (palette_index),
    .is_gray       (is_gray),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .last_out      (last_out)
  );

endmodule

// ===== tb/sv/rgb_cube_gray_quantizer_test.sv =====
// Self-checking testbench for the RGB to cube and gray ramp palette quantizer.
module rgb_cube_gray_quantizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcgq_pkg::*;

  localparam int unsigned CHANNEL_COUNT   = 3;
  localparam int unsigned RANDOM_WORDS    = 760;
  localparam int unsigned PRESSURE_WORDS  = 48;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned DRAIN_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned TIE_SEARCH      = 50000;
  localparam int unsigned TIE_TARGET      = 4;

  localparam int CORNER_COUNT = 19;
  localparam logic [23:0] CORNER_PIXELS [CORNER_COUNT] = '{
    24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
    24'hffff00, 24'h00ffff, 24'hff00ff, 24'h191919, 24'h1a1a1a,
    24'h808080, 24'h7f8081, 24'h555555, 24'haaaaaa, 24'h010203,
    24'hfefdfc, 24'h336699, 24'h4d4cb2, 24'hc80a5a
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [7:0] index;
    logic       gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } palette_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       pixel_valid = 1'b0;
  logic       pixel_stall;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic       last_pixel = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] palette_index;
  logic       is_gray;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       last_out;

  palette_word_t pending_words [$];
  int unsigned   error_count = 0;
  int unsigned   burst_left = 0;
  bit            free_run = 1'b0;
  bit            hold_off_request = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   stall_left = 0;
  stall_mode_t   stall_mode = STALL_NONE;

  rgb_cube_gray_quantizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .last_pixel   (last_pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .palette_index(palette_index),
    .is_gray      (is_gray),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .last_out     (last_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned square_diff(input int unsigned a, input int unsigned b);
    int unsigned d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  function automatic palette_word_t quantize_pixel(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b, input logic last,
                                                   output logic tie);
    int unsigned   lvl_r, lvl_g, lvl_b;
    int unsigned   cube_r, cube_g, cube_b;
    int unsigned   step, gray, cube_dist, gray_dist;
    palette_word_t w;
    lvl_r  = (int'(r) * (CUBE_LEVELS - 1) + HALF_ROUND) / FULL_SCALE;
    lvl_g  = (int'(g) * (CUBE_LEVELS - 1) + HALF_ROUND) / FULL_SCALE;
    lvl_b  = (int'(b) * (CUBE_LEVELS - 1) + HALF_ROUND) / FULL_SCALE;
    cube_r = lvl_r * FULL_SCALE / (CUBE_LEVELS - 1);
    cube_g = lvl_g * FULL_SCALE / (CUBE_LEVELS - 1);
    cube_b = lvl_b * FULL_SCALE / (CUBE_LEVELS - 1);
    step   = ((int'(r) + int'(g) + int'(b)) / CHANNEL_COUNT * GRAY_SPAN + HALF_ROUND)
             / FULL_SCALE;
    gray   = step * FULL_SCALE / GRAY_SPAN;
    cube_dist = square_diff(r, cube_r) + square_diff(g, cube_g) + square_diff(b, cube_b);
    gray_dist = square_diff(r, gray) + square_diff(g, gray) + square_diff(b, gray);
    tie = (cube_dist == gray_dist);
    if (gray_dist < cube_dist) begin
      w.index = 8'(CUBE_ENTRIES + step);
      w.gray  = 1'b1;
      w.red   = 8'(gray);
      w.green = 8'(gray);
      w.blue  = 8'(gray);
    end else begin
      w.index = 8'((lvl_r * CUBE_LEVELS + lvl_g) * CUBE_LEVELS + lvl_b);
      w.gray  = 1'b0;
      w.red   = 8'(cube_r);
      w.green = 8'(cube_g);
      w.blue  = 8'(cube_b);
    end
    w.last = last;
    return w;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic check_result();
    palette_word_t want;
    if (pending_words.size() == 0) begin
      report_error($sformatf("result word with index %0d arrived with none pending",
                             palette_index));
      return;
    end
    want = pending_words.pop_front();
    compare_field("palette_index", palette_index, want.index);
    compare_field("is_gray", is_gray, want.gray);
    compare_field("out_red", out_red, want.red);
    compare_field("out_green", out_green, want.green);
    compare_field("out_blue", out_blue, want.blue);
    compare_field("last_out", last_out, want.last);
  endtask

  // The receiver stalls in modes of random length; a hold-off request overrides them.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result();
      end
      if (hold_off_request) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(3));
        stall_left = $urandom_range(10, 60);
      end
      stall_left--;
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE: begin
            result_stall <= 1'b0;
          end
          STALL_LIGHT: begin
            result_stall <= ($urandom_range(3) == 0);
          end
          STALL_HEAVY: begin
            result_stall <= ($urandom_range(3) != 0);
          end
          default: begin
            result_stall <= stall_left[1];
          end
        endcase
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic last);
    palette_word_t want;
    logic          tie;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0 || free_run) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    want = quantize_pixel(r, g, b, last, tie);
    pixel_valid <= 1'b1;
    red_in      <= r;
    green_in    <= g;
    blue_in     <= b;
    last_pixel  <= last;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pending_words.push_back(want);
  endtask

  function automatic logic [7:0] level_edge_value();
    return 8'(25 + 51 * $urandom_range(4) + $urandom_range(1));
  endfunction

  function automatic logic [7:0] near_value(input int unsigned base);
    return 8'(int'(base) + int'($urandom_range(12)) - 6);
  endfunction

  task automatic test_corners();
    for (int n = 0; n < CORNER_COUNT; n++) begin
      send_pixel(CORNER_PIXELS[n][23:16], CORNER_PIXELS[n][15:8], CORNER_PIXELS[n][7:0],
                 logic'(n % 2));
    end
  endtask

  // Pixels whose gray and cube errors are equal must map to the cube entry.
  task automatic test_equal_errors();
    logic [7:0]    r, g, b;
    logic          tie;
    int unsigned   found;
    int unsigned   base;
    found = 0;
    for (int n = 0; n < TIE_SEARCH && found < TIE_TARGET; n++) begin
      base = $urandom_range(6, 249);
      r = near_value(base);
      g = near_value(base);
      b = near_value(base);
      void'(quantize_pixel(r, g, b, 1'b0, tie));
      if (tie && !(r == g && g == b)) begin
        send_pixel(r, g, b, logic'(found % 2));
        found++;
      end
    end
  endtask

  task automatic test_random_pixels();
    logic [7:0]  r, g, b;
    int unsigned base;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      case ($urandom_range(3))
        0: begin
          base = $urandom_range(6, 249);
          r = near_value(base);
          g = near_value(base);
          b = near_value(base);
        end
        1: begin
          r = level_edge_value();
          g = level_edge_value();
          b = level_edge_value();
        end
        default: begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end
      endcase
      send_pixel(r, g, b, ($urandom_range(15) == 0));
    end
  endtask

  task automatic test_backpressure();
    free_run = 1'b1;
    hold_off_request = 1'b1;
    for (int n = 0; n < PRESSURE_WORDS; n++) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), ($urandom_range(7) == 0));
    end
    free_run = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_corners();
    test_equal_errors();
    test_random_pixels();
    test_backpressure();
    pixel_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_words.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      report_error($sformatf("%0d result words never arrived", pending_words.size()));
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rcgq_pkg.sv
design/rcgq_level.sv
design/rcgq_select.sv
design/rgb_cube_gray_quantizer.sv
tb/sv/rgb_cube_gray_quantizer_test.sv
